@@ hdl/nec_ir_pulse_decoder_core_macros.svh @@
// Assertion macros used by the NEC IR decoder checker.
// Assumes clk_i and rst_ni are visible where a macro is used.
`ifndef NEC_IR_PULSE_DECODER_CORE_MACROS_SVH
`define NEC_IR_PULSE_DECODER_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define NEC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nec_ir assertion failed");

// Same, for an implication written as antecedent and consequent.
`define NEC_ASSERT_IMP(lbl, ante, cons) \
  `NEC_ASSERT(lbl, (ante) |-> (cons))

`endif

@@ hdl/nec_ir_pkg.sv @@
// Package for the NEC IR pulse decoder: types, register map, helpers.
// No dependencies.
`default_nettype none
package nec_ir_pkg;

  localparam int CHANNELS   = 4;
  localparam int FRAME_BITS = 32;

  localparam int CH_W      = 2;
  localparam int CAP_W     = 16;
  localparam int CODE_W    = 32;
  localparam int OVF_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  // bit counter holds 0..FRAME_BITS
  localparam int BCNT_W    = $clog2(FRAME_BITS + 2);
  // width = cap + ovf * period - rise, clamped at zero
  localparam int PROD_W    = OVF_W + CFG_W;
  localparam int W_W       = PROD_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_TIMER_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REP_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REP_SECOND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESH   = 3'd5;

  localparam logic OP_CAPTURE  = 1'b0;
  localparam logic OP_OVERFLOW = 1'b1;

  typedef struct packed {
    logic             op;
    logic [CH_W-1:0]  channel;
    logic [CAP_W-1:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]   out_channel;
    logic [CODE_W-1:0] code;
    logic              is_repeat;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] timer_period;
    logic [CFG_W-1:0] boot_width;
    logic [CFG_W-1:0] repeat_first_width;
    logic [CFG_W-1:0] repeat_second_width;
    logic [CFG_W-1:0] width_tolerance;
    logic [CFG_W-1:0] one_threshold;
  } cfg_t;

  // nom +/- tol; a negative lower bound admits zero
  function automatic logic in_window(logic [W_W-1:0] w, logic [CFG_W-1:0] nom,
                                     logic [CFG_W-1:0] tol);
    logic [CFG_W:0]   hi;
    logic [CFG_W-1:0] lo;
    logic             lo_neg;
    hi     = {1'b0, nom} + {1'b0, tol};
    lo     = nom - tol;
    lo_neg = tol > nom;
    return (lo_neg || (w >= W_W'(lo))) && (w <= W_W'(hi));
  endfunction

endpackage
`default_nettype wire

@@ hdl/nec_ir_cfg_regs.sv @@
// Configuration register file of the NEC IR decoder.
// Depends on nec_ir_pkg.
`default_nettype none
module nec_ir_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nec_ir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nec_ir_pkg::CFG_W-1:0]     cfg_wdata_i,
  output nec_ir_pkg::cfg_t                cfg_o
);
  import nec_ir_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TIMER_PERIOD: cfg_d.timer_period        = cfg_wdata_i;
        REG_BOOT_WIDTH:   cfg_d.boot_width          = cfg_wdata_i;
        REG_REP_FIRST:    cfg_d.repeat_first_width  = cfg_wdata_i;
        REG_REP_SECOND:   cfg_d.repeat_second_width = cfg_wdata_i;
        REG_TOLERANCE:    cfg_d.width_tolerance     = cfg_wdata_i;
        REG_ONE_THRESH:   cfg_d.one_threshold       = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_period        <= 16'd65535;
      cfg_q.boot_width          <= 16'd4500;
      cfg_q.repeat_first_width  <= 16'd2250;
      cfg_q.repeat_second_width <= 16'd560;
      cfg_q.width_tolerance     <= 16'd200;
      cfg_q.one_threshold       <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ hdl/nec_ir_decode.sv @@
// Per-channel state and single-pass decode step of the NEC IR decoder.
// Depends on nec_ir_pkg.
`default_nettype none
module nec_ir_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  nec_ir_pkg::in_item_t  item_i,
  input  nec_ir_pkg::cfg_t      cfg_i,
  output logic                  res_vld_o,
  output nec_ir_pkg::out_item_t res_o
);
  import nec_ir_pkg::*;

  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_FRAME = 2'd1;
  localparam logic [1:0] PH_REP   = 2'd2;

  typedef struct packed {
    logic              expect_rising;
    logic [CAP_W-1:0]  rise_time;
    logic [OVF_W-1:0]  overflow_count;
    logic [1:0]        repeat_phase;
    logic [BCNT_W-1:0] bit_count;
    logic [CODE_W-1:0] shift_bits;
    logic [CODE_W-1:0] saved_code;
  } chan_st_t;

  chan_st_t st_q [CHANNELS];

  chan_st_t             cur, nxt;
  logic [CHANNELS-1:0]  ch_hit;
  logic [PROD_W-1:0]    prod;
  logic [W_W-1:0]       sum, w;
  logic [BCNT_W-1:0]    pos;
  logic [CODE_W-1:0]    bit_mask;
  logic                 rep, frame_done;

  // channel select; channels past CHANNELS never hit
  always_comb begin
    cur    = '0;
    ch_hit = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(item_i.channel) == i) begin
        ch_hit[i] = 1'b1;
        cur       = st_q[i];
      end
    end
  end

  always_comb begin
    prod = PROD_W'(cur.overflow_count) * PROD_W'(cfg_i.timer_period);
    sum  = W_W'(item_i.capture_value) + W_W'(prod);
    w    = (sum >= W_W'(cur.rise_time)) ? sum - W_W'(cur.rise_time) : '0;
    pos  = cur.bit_count - BCNT_W'(1);
    bit_mask = '0;
    for (int j = 0; j < CODE_W; j++) begin
      if (int'(pos) == j) bit_mask[j] = 1'b1;
    end
  end

  always_comb begin
    nxt        = cur;
    rep        = 1'b0;
    frame_done = 1'b0;
    if (item_i.op == OP_OVERFLOW) begin
      if (cur.overflow_count != '1) nxt.overflow_count = cur.overflow_count + OVF_W'(1);
    end else if (cur.expect_rising) begin
      nxt.rise_time      = item_i.capture_value;
      nxt.overflow_count = '0;
      nxt.expect_rising  = 1'b0;
    end else begin
      nxt.expect_rising = 1'b1;
      case (cur.repeat_phase)
        PH_FRAME: begin
          if (in_window(w, cfg_i.repeat_first_width, cfg_i.width_tolerance))
            nxt.repeat_phase = PH_REP;
        end
        PH_REP: begin
          if (in_window(w, cfg_i.repeat_second_width, cfg_i.width_tolerance)) begin
            nxt.repeat_phase = PH_FRAME;
            rep              = 1'b1;
          end
        end
        default: nxt.repeat_phase = cur.repeat_phase;
      endcase
      if (in_window(w, cfg_i.boot_width, cfg_i.width_tolerance)) begin
        nxt.bit_count  = BCNT_W'(1);
        nxt.shift_bits = '0;
      end else if (cur.bit_count != '0) begin
        if (w > W_W'(cfg_i.one_threshold)) nxt.shift_bits = cur.shift_bits | bit_mask;
        nxt.bit_count = cur.bit_count + BCNT_W'(1);
        if (cur.bit_count == BCNT_W'(FRAME_BITS)) begin
          frame_done       = 1'b1;
          nxt.bit_count    = '0;
          nxt.repeat_phase = PH_FRAME;
          nxt.saved_code   = nxt.shift_bits;
        end
      end
    end
  end

  // a finished frame wins over a repeat ending on the same pulse
  always_comb begin
    res_vld_o         = (|ch_hit) && (frame_done || rep);
    res_o.out_channel = item_i.channel;
    res_o.code        = frame_done ? nxt.shift_bits : cur.saved_code;
    res_o.is_repeat   = !frame_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) st_q[i] <= '0;
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (step_i && ch_hit[i]) st_q[i] <= nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/nec_ir_pulse_decoder_core.sv @@
// Top level of the four-channel NEC IR pulse decoder.
// Depends on nec_ir_pkg, nec_ir_cfg_regs, nec_ir_decode.
//
//   port group   direction  handshake               payload
//   in_*         in         in_valid_i / in_stall_o  in_item_i (op, channel, capture_value)
//   out_*        out        out_valid_o / out_stall_i out_item_o (out_channel, code, is_repeat)
//   cfg_*        in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_wdata_i
//
// An event is registered in in_q at accept and decoded from there once the
// output register is free; its result is registered in out_q and shows on
// out_* from there.
// One event per cycle sustained while out_* is not stalled; the per-channel state update is one pass.
// Reset clears all channel state and loads the default register values.
// A stalled result holds the output register; one more event may wait in
// the input register, after which in_stall_o rises.
`default_nettype none
module nec_ir_pulse_decoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  nec_ir_pkg::in_item_t             in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output nec_ir_pkg::out_item_t            out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nec_ir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nec_ir_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import nec_ir_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_item_t out_q, res;
  logic      out_vld_q, out_vld_d;
  logic      res_vld, out_free, advance, in_acc;

  nec_ir_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  nec_ir_decode u_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_comb begin
    in_vld_d = in_acc ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    out_vld_d = out_free ? (advance && res_vld) : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_item_i;
    if (out_free && advance) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

@@ hdl/nec_ir_checker.sv @@
// Port-level checker for the NEC IR decoder, bound to the top level.
// Depends on nec_ir_pkg and nec_ir_pulse_decoder_core_macros.svh.
`default_nettype none
`include "nec_ir_pulse_decoder_core_macros.svh"
module nec_ir_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input nec_ir_pkg::in_item_t             in_item_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input nec_ir_pkg::out_item_t            out_item_o,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [nec_ir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [nec_ir_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import nec_ir_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_item_i, cfg_valid_i, cfg_index_i, cfg_wdata_i};

  // a fresh result beat comes from an event accepted earlier
  `NEC_ASSERT_IMP(a_res_after_event, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2))
  // input backpressure only from a stalled, full output
  `NEC_ASSERT_IMP(a_stall_from_out, in_stall_o, out_valid_o && out_stall_i)
  // config port never blocks once out of reset
  `NEC_ASSERT(a_cfg_ready, cfg_ready_o)
  // a stalled result beat holds
  `NEC_ASSERT_IMP(a_out_hold, out_valid_o && out_stall_i, ##1 (out_valid_o && $stable(out_item_o)))

endmodule

bind nec_ir_pulse_decoder_core nec_ir_checker u_nec_ir_checker (.*);
`default_nettype wire
